// File: design/arx_pkg.sv
package arx_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int FRAC_BITS  = 12;
    localparam int ACC_W      = 40;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int Y_W        = ACC_W - FRAC_BITS;
    localparam int MAX_DELAY  = 16;
    localparam int A_TAPS     = 3;
    localparam int B_TAPS     = 3;
    localparam int HIST_DEPTH = MAX_DELAY + B_TAPS - 1;
    localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
    localparam int DELAY_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic [DELAY_W-1:0]         t_delay;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;

    localparam t_cfg_idx CFG_A_COEF_1       = 3'd0;
    localparam t_cfg_idx CFG_A_COEF_2       = 3'd1;
    localparam t_cfg_idx CFG_A_COEF_3       = 3'd2;
    localparam t_cfg_idx CFG_B_COEF_0       = 3'd3;
    localparam t_cfg_idx CFG_B_COEF_1       = 3'd4;
    localparam t_cfg_idx CFG_B_COEF_2       = 3'd5;
    localparam t_cfg_idx CFG_TRANSPORT_DELAY = 3'd6;

    localparam t_coef  B_COEF_0_RESET = t_coef'(1 << FRAC_BITS);
    localparam t_delay DELAY_RESET    = t_delay'(1);
    localparam t_delay DELAY_MAX      = t_delay'(MAX_DELAY);

    localparam logic signed [Y_W-1:0] SAT_HI = Y_W'((2 ** (SAMPLE_W - 1)) - 1);
    localparam logic signed [Y_W-1:0] SAT_LO = -SAT_HI - Y_W'(1);

endpackage

// File: design/arx_in_if.sv
interface arx_in_if;
    import arx_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

// File: design/arx_out_if.sv
interface arx_out_if;
    import arx_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample_out;
    logic    saturated;

    modport source (output valid, output sample_out, output saturated, input ready);
    modport sink (input valid, input sample_out, input saturated, output ready);
endinterface

// File: design/arx_model_step_core.sv
// An accepted input word's result is registered onto o_out in the next cycle.
// Throughput: one word per cycle unless stalled; the six products, their sum and the
// saturation sit between the history registers and the single output register.
// i_in.ready falls only while the output register holds a word that is not taken.
// Reset (synchronous, active low) clears both histories, the output valid and
// sets coefficients to zero except b_coef_0 = 1.0, with transport delay one.
module arx_model_step_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [arx_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [arx_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    arx_in_if.sink                          i_in,
    arx_out_if.source                       o_out
);
    import arx_pkg::*;

    t_coef   r_a_coef [A_TAPS];
    t_coef   r_b_coef [B_TAPS];
    t_delay  r_delay;
    t_sample r_in_hist [HIST_DEPTH];
    t_sample r_out_hist [A_TAPS];
    logic    r_out_valid;
    t_sample r_sample_out;
    logic    r_saturated;

    logic                              in_ready;
    logic                              accept;
    t_delay                            d_eff;
    logic [HIST_IDX_W-1:0]             base;
    logic [HIST_DEPTH*SAMPLE_W-1:0]    hist_flat;
    logic [B_TAPS*SAMPLE_W-1:0]        window;
    logic signed [PROD_W-1:0]          b_prod [B_TAPS];
    logic signed [PROD_W-1:0]          a_prod [A_TAPS];
    logic signed [ACC_W-1:0]           acc;
    logic signed [Y_W-1:0]             y_full;
    t_sample                           n_sample_out;
    logic                              n_saturated;

    assign in_ready = !r_out_valid || o_out.ready;
    assign accept   = i_in.valid && in_ready;

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_sample_out;
    assign o_out.saturated  = r_saturated;

    always_comb begin
        if (r_delay == t_delay'(0)) begin
            d_eff = t_delay'(1);
        end else if (r_delay > DELAY_MAX) begin
            d_eff = DELAY_MAX;
        end else begin
            d_eff = r_delay;
        end
    end

    assign base = HIST_IDX_W'(d_eff - t_delay'(1));

    always_comb begin
        for (int j = 0; j < HIST_DEPTH; j++) begin
            hist_flat[j*SAMPLE_W +: SAMPLE_W] = r_in_hist[j];
        end
    end

    assign window = hist_flat[base*SAMPLE_W +: B_TAPS*SAMPLE_W];

    always_comb begin
        acc = '0;
        for (int i = 0; i < B_TAPS; i++) begin
            b_prod[i] = r_b_coef[i] * t_sample'(window[i*SAMPLE_W +: SAMPLE_W]);
            acc = acc + ACC_W'(b_prod[i]);
        end
        for (int i = 0; i < A_TAPS; i++) begin
            a_prod[i] = r_a_coef[i] * r_out_hist[i];
            acc = acc - ACC_W'(a_prod[i]);
        end
    end

    assign y_full = acc[ACC_W-1:FRAC_BITS];

    always_comb begin
        if (y_full > SAT_HI) begin
            n_sample_out = t_sample'(SAT_HI);
            n_saturated  = 1'b1;
        end else if (y_full < SAT_LO) begin
            n_sample_out = t_sample'(SAT_LO);
            n_saturated  = 1'b1;
        end else begin
            n_sample_out = y_full[SAMPLE_W-1:0];
            n_saturated  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < A_TAPS; i++) begin
                r_a_coef[i] <= '0;
            end
            for (int i = 0; i < B_TAPS; i++) begin
                r_b_coef[i] <= '0;
            end
            r_b_coef[0] <= B_COEF_0_RESET;
            r_delay     <= DELAY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_A_COEF_1:        r_a_coef[0] <= t_coef'(i_cfg_data);
                CFG_A_COEF_2:        r_a_coef[1] <= t_coef'(i_cfg_data);
                CFG_A_COEF_3:        r_a_coef[2] <= t_coef'(i_cfg_data);
                CFG_B_COEF_0:        r_b_coef[0] <= t_coef'(i_cfg_data);
                CFG_B_COEF_1:        r_b_coef[1] <= t_coef'(i_cfg_data);
                CFG_B_COEF_2:        r_b_coef[2] <= t_coef'(i_cfg_data);
                CFG_TRANSPORT_DELAY: r_delay     <= i_cfg_data[DELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // advance both histories on every accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < HIST_DEPTH; j++) begin
                r_in_hist[j] <= '0;
            end
            for (int i = 0; i < A_TAPS; i++) begin
                r_out_hist[i] <= '0;
            end
        end else if (accept) begin
            for (int j = HIST_DEPTH - 1; j > 0; j--) begin
                r_in_hist[j] <= r_in_hist[j-1];
            end
            r_in_hist[0] <= i_in.sample_in;
            for (int i = A_TAPS - 1; i > 0; i--) begin
                r_out_hist[i] <= r_out_hist[i-1];
            end
            r_out_hist[0] <= n_sample_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample_out <= n_sample_out;
            r_saturated  <= n_saturated;
        end
    end

`ifndef SYNTHESIS
    a_accept_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && accept) |=> r_out_valid)
        else $error("accepted word produced no result");

    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while result register is stalled");

    a_feedback_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && accept) |=> (r_out_hist[0] == r_sample_out))
        else $error("fed-back output differs from delivered result");

    a_in_hist_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && accept) |=> (r_in_hist[0] == $past(i_in.sample_in)))
        else $error("input history missed the accepted sample");

    a_sat_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_saturated) |->
            (r_sample_out == t_sample'(SAT_HI) || r_sample_out == t_sample'(SAT_LO)))
        else $error("saturation flag set off the rails");
`endif

endmodule
